[hw/rtl/g2r_pkg.sv]
// Shared types, codes and string tables for the glob-to-regex translator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package g2r_pkg;

  // Commands carried in the input tuser
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_CHAR  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  // Substitution modes
  localparam logic [1:0] MODE_FILE      = 2'd0;
  localparam logic [1:0] MODE_TAR       = 2'd1;
  localparam logic [1:0] MODE_WORD_DOT  = 2'd3;

  // Anchor kinds, shared by start and end items
  localparam logic [2:0] ANC_NONE   = 3'd0;
  localparam logic [2:0] ANC_CARET  = 3'd1;
  localparam logic [2:0] ANC_SEP    = 3'd2;
  localparam logic [2:0] ANC_BOTH   = 3'd3;
  localparam logic [2:0] ANC_ALT    = 3'd4;

  // Register map
  localparam logic REG_SUBST_MODE = 1'b0;

  // Character codes
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_PIPE   = 8'h7C;

  localparam int SEG_MAX  = 5;
  localparam int DESC_MAX = 2 * SEG_MAX;

  // Short string of up to five bytes, byte 0 first
  typedef struct packed {
    logic [SEG_MAX-1:0][7:0] b;
    logic [2:0]              n;
  } seg_t;

  // Bytes produced by one input item, byte 0 first
  typedef struct packed {
    logic [DESC_MAX-1:0][7:0] b;
    logic [3:0]               cnt;
  } desc_t;

  function automatic seg_t mk_seg(input logic [2:0] n, input logic [7:0] b0,
                                  input logic [7:0] b1, input logic [7:0] b2,
                                  input logic [7:0] b3, input logic [7:0] b4);
    seg_t s;
    s.n    = n;
    s.b[0] = b0;
    s.b[1] = b1;
    s.b[2] = b2;
    s.b[3] = b3;
    s.b[4] = b4;
    return s;
  endfunction

  function automatic seg_t seg_empty();
    return mk_seg(3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endfunction

  function automatic logic [7:0] sep_char(input logic [1:0] mode);
    return (mode == MODE_WORD_DOT) ? CH_DOT : CH_SLASH;
  endfunction

  function automatic logic is_word(input logic [1:0] mode);
    return mode[1];
  endfunction

  function automatic seg_t star_seg(input logic [1:0] mode);
    if (mode == MODE_TAR) return mk_seg(3'd2, CH_DOT, CH_STAR, 8'h00, 8'h00, 8'h00);
    return mk_seg(3'd5, CH_LBRACK, CH_CARET, sep_char(mode), CH_RBRACK, CH_STAR);
  endfunction

  function automatic seg_t qmark_seg(input logic [1:0] mode);
    return mk_seg(3'd4, CH_LBRACK, CH_CARET, sep_char(mode), CH_RBRACK, 8'h00);
  endfunction

  function automatic logic is_meta(input logic [7:0] c);
    return c inside {CH_DOT, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                     CH_PLUS, CH_CARET, CH_DOLLAR, CH_PIPE};
  endfunction

  function automatic seg_t begin_seg(input logic [2:0] kind, input logic [1:0] mode);
    seg_t s;
    case (kind)
      ANC_CARET: s = mk_seg(3'd1, CH_CARET, 8'h00, 8'h00, 8'h00, 8'h00);
      ANC_SEP:   s = mk_seg(3'd2, CH_BSLASH, sep_char(mode), 8'h00, 8'h00, 8'h00);
      ANC_BOTH:  s = mk_seg(3'd3, CH_CARET, CH_BSLASH, sep_char(mode), 8'h00, 8'h00);
      ANC_ALT:   s = mk_seg(3'd5, CH_LPAREN, CH_CARET, CH_PIPE, CH_SLASH, CH_RPAREN);
      default:   s = seg_empty();
    endcase
    return s;
  endfunction

  function automatic seg_t end_seg(input logic [2:0] kind, input logic [1:0] mode);
    seg_t s;
    case (kind)
      ANC_CARET: s = mk_seg(3'd1, CH_DOLLAR, 8'h00, 8'h00, 8'h00, 8'h00);
      ANC_SEP:   s = mk_seg(3'd2, CH_BSLASH, sep_char(mode), 8'h00, 8'h00, 8'h00);
      ANC_BOTH:  s = mk_seg(3'd3, CH_BSLASH, sep_char(mode), CH_DOLLAR, 8'h00, 8'h00);
      ANC_ALT:   s = mk_seg(3'd5, CH_LPAREN, CH_DOLLAR, CH_PIPE, CH_SLASH, CH_RPAREN);
      default:   s = seg_empty();
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/g2r_front.sv]
// Front end: accepts pattern items, tracks the parse state and builds the
// byte string each item produces. Depends on g2r_pkg.
`default_nettype none

module g2r_front import g2r_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] cmd,
  input  wire logic [7:0] char_in,
  input  wire logic [2:0] anchor_kind,
  input  wire logic [1:0] mode,
  input  wire logic       q_full,
  output logic            push,
  output desc_t           push_data
);

  logic in_class, quote_open, class_just_opened, prev_backslash, star_pending;
  logic in_class_next, quote_open_next, class_just_opened_next;
  logic prev_backslash_next, star_pending_next;
  logic accept;
  seg_t pre, main;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Work out the strings and the next parse state for the offered item
  always_comb begin
    logic done;
    done                   = 1'b0;
    pre                    = seg_empty();
    main                   = seg_empty();
    in_class_next          = in_class;
    quote_open_next        = quote_open;
    class_just_opened_next = class_just_opened;
    prev_backslash_next    = prev_backslash;
    star_pending_next      = star_pending;
    case (cmd)
      CMD_START: begin
        in_class_next          = 1'b0;
        quote_open_next        = 1'b0;
        class_just_opened_next = 1'b0;
        prev_backslash_next    = 1'b0;
        star_pending_next      = 1'b0;
        main                   = begin_seg(anchor_kind, mode);
      end
      CMD_CHAR: begin
        // Resolve a held star: a second star in a word mode gives ".*"
        if (star_pending) begin
          star_pending_next = 1'b0;
          if (char_in == CH_STAR && is_word(mode)) begin
            main = mk_seg(3'd2, CH_DOT, CH_STAR, 8'h00, 8'h00, 8'h00);
            prev_backslash_next = 1'b0;
            done = 1'b1;
          end else begin
            pre = star_seg(mode);
          end
        end
        // Negated class right after the opening bracket
        if (!done && class_just_opened) begin
          class_just_opened_next = 1'b0;
          if (char_in == CH_BANG) begin
            main = mk_seg(3'd1, CH_CARET, 8'h00, 8'h00, 8'h00, 8'h00);
            prev_backslash_next = 1'b0;
            done = 1'b1;
          end
        end
        if (!done) begin
          if (in_class) begin
            in_class_next = (char_in != CH_RBRACK) || prev_backslash;
            main = mk_seg(3'd1, char_in, 8'h00, 8'h00, 8'h00, 8'h00);
          end else if (quote_open) begin
            quote_open_next = 1'b0;
            main = mk_seg(3'd1, char_in, 8'h00, 8'h00, 8'h00, 8'h00);
          end else if (char_in == CH_BSLASH) begin
            quote_open_next = 1'b1;
            main = mk_seg(3'd1, char_in, 8'h00, 8'h00, 8'h00, 8'h00);
          end else if (char_in == CH_LBRACK) begin
            in_class_next          = 1'b1;
            class_just_opened_next = 1'b1;
            main = mk_seg(3'd1, char_in, 8'h00, 8'h00, 8'h00, 8'h00);
          end else if (is_meta(char_in)) begin
            main = mk_seg(3'd2, CH_BSLASH, char_in, 8'h00, 8'h00, 8'h00);
          end else if (char_in == CH_QMARK) begin
            main = qmark_seg(mode);
          end else if (char_in == CH_STAR) begin
            if (is_word(mode)) star_pending_next = 1'b1;
            else main = star_seg(mode);
          end else begin
            main = mk_seg(3'd1, char_in, 8'h00, 8'h00, 8'h00, 8'h00);
          end
          prev_backslash_next = (char_in == CH_BSLASH);
        end
      end
      CMD_END: begin
        if (star_pending) pre = star_seg(mode);
        if (!quote_open) main = end_seg(anchor_kind, mode);
        in_class_next          = 1'b0;
        quote_open_next        = 1'b0;
        class_just_opened_next = 1'b0;
        prev_backslash_next    = 1'b0;
        star_pending_next      = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Join the star prefix and the main string into one descriptor
  always_comb begin
    logic [3:0] j;
    j = 4'd0;
    push_data.cnt = {1'b0, pre.n} + {1'b0, main.n};
    for (int i = 0; i < DESC_MAX; i++) begin
      j = 4'(i) - {1'b0, pre.n};
      if (4'(i) < {1'b0, pre.n}) push_data.b[i] = pre.b[i % SEG_MAX];
      else if (j < 4'(SEG_MAX)) push_data.b[i] = main.b[j[2:0]];
      else push_data.b[i] = 8'h00;
    end
  end

  assign push = accept && (push_data.cnt != 4'd0);

  // Advance the parse state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_class          <= 1'b0;
      quote_open        <= 1'b0;
      class_just_opened <= 1'b0;
      prev_backslash    <= 1'b0;
      star_pending      <= 1'b0;
    end else if (accept) begin
      in_class          <= in_class_next;
      quote_open        <= quote_open_next;
      class_just_opened <= class_just_opened_next;
      prev_backslash    <= prev_backslash_next;
      star_pending      <= star_pending_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/g2r_queue.sv]
// Two-entry descriptor queue between the front and back ends.
// Depends on g2r_pkg for the descriptor type.
`default_nettype none

module g2r_queue import g2r_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire desc_t push_data,
  output logic       full,
  input  wire logic  pop,
  output logic       head_valid,
  output desc_t      head
);

  desc_t      slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];

  // Write the new descriptor
  always_ff @(posedge clk) begin
    if (push && !full) slot[wr_ptr] <= push_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= !wr_ptr;
      if (pop && head_valid) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push && !full} - {1'b0, pop && head_valid};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/g2r_back.sv]
// Back end: walks the head descriptor one byte per beat into the output
// register and marks the final byte. Depends on g2r_pkg.
`default_nettype none

module g2r_back import g2r_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       head_valid,
  input  wire desc_t      head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_data,
  output logic            out_last
);

  logic [3:0] pos;
  logic       load, at_end;

  assign load   = head_valid && (!out_valid || out_ready);
  assign at_end = (pos == head.cnt - 4'd1);
  assign pop    = load && at_end;

  // Step through the bytes of the head descriptor
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= at_end ? 4'd0 : pos + 4'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the output byte until taken
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= head.b[pos];
      out_last <= at_end;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/glob_to_regex_translator_top.sv]
// Top level of the glob-to-regex translator: stream ports, register port,
// and the front end, queue and back end. Depends on g2r_pkg.
//
// Pattern items arrive one per beat (tuser: start, character or end) and each
// produces zero to ten regex bytes, sent one byte per beat with tlast on the
// final byte of that item. The back-end serializer sets the rate: plain bytes
// run at one item per cycle while the output is not stalled, and expansions
// hold the input back once the queue fills. A two-deep queue of byte strings
// lets input be taken while output stalls; the first byte of an item passes
// through the queue and then the output register. subst_mode sits at byte
// address 0; the user must write it only when idle, the block does not enforce it.
`default_nettype none

module glob_to_regex_translator_top import g2r_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // pattern input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [7:0] char_in, [10:8] anchor_kind
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] cmd
  // regex output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] char_out
  output logic             m_axis_tlast
);

  logic [1:0] subst_mode;
  logic       q_full, push, pop, head_valid;
  desc_t      push_data, head;

  // Register file: one mode register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SUBST_MODE) ? {30'd0, subst_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      subst_mode <= MODE_FILE;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SUBST_MODE) begin
      subst_mode <= pwdata[1:0];
    end
  end

  g2r_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .cmd         (s_axis_tuser),
    .char_in     (s_axis_tdata[7:0]),
    .anchor_kind (s_axis_tdata[10:8]),
    .mode        (subst_mode),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  g2r_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  g2r_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule

`default_nettype wire

[hw/rtl/g2r_checker.sv]
// Port-level checks for the glob-to-regex translator, bound to the top level.
// Depends on g2r_pkg for the register map and on the top level's ports.
`default_nettype none

module g2r_checker import g2r_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [2:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // A stalled output byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // Reset empties the output
  a_rst_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // A mode write reads back on the next cycle
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && paddr[2] == REG_SUBST_MODE |=>
      paddr[2] != REG_SUBST_MODE || prdata[1:0] == $past(pwdata[1:0]))
    else $error("mode register readback mismatch");

  // Register port is always ready and unused bits read zero
  a_regport: assert property (@(posedge clk) pready && prdata[31:2] == 30'd0)
    else $error("register port misbehaves");

endmodule

bind glob_to_regex_translator_top g2r_checker u_g2r_checker (
  .clk           (clk),
  .rst           (rst),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
